// ===== design/twd_pkg.sv =====
`timescale 1ns / 1ps

package twd_pkg;

    localparam int TD_W       = 24;
    localparam int Q_W        = 48;
    localparam int NX_W       = 50;
    localparam int NY_W       = 49;
    localparam int M_W        = 31;
    localparam int M2_W       = 62;
    localparam int SQ_W       = 32;
    localparam int QUO_W      = 33;
    localparam int RAD_W      = 34;
    localparam int ROOT_W     = 17;
    localparam int REM_W      = 19;
    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 17;
    localparam int FRAC_BITS  = 30;

    localparam logic [20:0] SPEED_NUM = 21'd1500000;

    // register indexes of the configuration port
    localparam logic [1:0] REG_SENSOR_RADIUS = 2'd0;
    localparam logic [1:0] REG_SPEED_MAX     = 2'd1;
    localparam logic [1:0] REG_SPEED_MIN     = 2'd2;

    typedef struct packed {
        logic signed [23:0] time_diff_left;
        logic signed [23:0] time_diff_right;
    } twd_in_t;

    typedef struct packed {
        logic               estimate_valid;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [15:0]        wind_speed;
    } twd_out_t;

    // classified item handed from front to back
    typedef struct packed {
        logic            zero;
        logic            neg_x;
        logic            neg_y;
        logic [Q_W-1:0]  q;
        logic [NX_W-1:0] nx;
        logic [NY_W-1:0] ny;
    } twd_job_t;

    // values derived from the configuration registers
    typedef struct packed {
        logic [M2_W-1:0] m2;
        logic [SQ_W-1:0] min_sq;
        logic [SQ_W-1:0] max_sq;
    } twd_cfg_t;

    typedef struct packed {
        logic [Q_W-1:0]   r;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } twd_div_lane_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } twd_sqrt_lane_t;

    typedef struct packed {
        logic           zero;
        logic           big;
        logic           neg_x;
        logic           neg_y;
        logic [Q_W-1:0] d;
    } twd_dmeta_t;

    typedef struct packed {
        logic zero;
        logic big;
        logic ok;
        logic neg_x;
        logic neg_y;
    } twd_smeta_t;

    // one restoring division step
    function automatic twd_div_lane_t div_step(twd_div_lane_t l, logic [Q_W-1:0] d);
        logic [Q_W:0]  t;
        twd_div_lane_t n;
        t     = {l.r, l.low[QUO_W-1]};
        n.low = {l.low[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            n.r   = Q_W'(t - {1'b0, d});
            n.quo = {l.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            n.r   = t[Q_W-1:0];
            n.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // one digit of the integer square root
    function automatic twd_sqrt_lane_t sqrt_step(twd_sqrt_lane_t l);
        logic [REM_W+1:0] t;
        logic [REM_W-1:0] trial;
        twd_sqrt_lane_t   n;
        t     = {l.rem, l.rad[RAD_W-1:RAD_W-2]};
        trial = {l.root, 2'b01};
        n.rad = {l.rad[RAD_W-3:0], 2'b00};
        if (t >= {2'b00, trial})
        begin
            n.rem  = REM_W'(t - {2'b00, trial});
            n.root = {l.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = REM_W'(t);
            n.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // round a root of four times the square to Q1.15, saturate, apply sign
    function automatic logic signed [15:0] q15_signed(logic [ROOT_W-1:0] root, logic neg);
        logic [ROOT_W:0]   sum;
        logic [ROOT_W-1:0] m;
        logic [15:0]       mag;
        sum = {1'b0, root} + (ROOT_W+1)'(1);
        m   = sum[ROOT_W:1];
        mag = (m > ROOT_W'(32767)) ? 16'd32767 : m[15:0];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ===== design/twd_front.sv =====
`timescale 1ns / 1ps

module twd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  twd_pkg::twd_in_t  in_data,
    output logic              push,
    output twd_pkg::twd_job_t push_job,
    input  logic              q_full
);
    import twd_pkg::*;

    logic fe;

    logic                   f1_vld_reg, f2_vld_reg, f3_vld_reg;
    logic signed [TD_W-1:0] a_reg, b_reg;
    logic signed [Q_W-1:0]  aa_reg, ab_reg, bb_reg;
    logic signed [Q_W-1:0]  aa_next, ab_next, bb_next;
    logic [NX_W-1:0]        ud2_reg, ud2_next;
    logic [NY_W-1:0]        us2_reg, us2_next;
    logic                   zero_reg, negx_reg, negy_reg;
    logic                   zero_next, negx_next, negy_next;
    twd_job_t               job_reg, job_next;

    logic signed [TD_W:0]   dif, sum;
    logic [TD_W:0]          ud, us;
    logic signed [Q_W+1:0]  qs;

    assign fe       = !f3_vld_reg || !q_full;
    assign in_stall = !fe;
    assign push     = f3_vld_reg && !q_full;
    assign push_job = job_reg;

    // products of the two differences, squared difference and sum, zero and sign flags
    always_comb
    begin
        dif       = $signed({a_reg[TD_W-1], a_reg}) - $signed({b_reg[TD_W-1], b_reg});
        sum       = $signed({a_reg[TD_W-1], a_reg}) + $signed({b_reg[TD_W-1], b_reg});
        ud        = dif[TD_W] ? 25'(-dif) : dif;
        us        = sum[TD_W] ? 25'(-sum) : sum;
        aa_next   = a_reg * a_reg;
        ab_next   = a_reg * b_reg;
        bb_next   = b_reg * b_reg;
        ud2_next  = ud * ud;
        us2_next  = NY_W'(ud2_next - ud2_next + us * us);
        zero_next = (a_reg == '0) && (b_reg == '0);
        negx_next = dif[TD_W];
        negy_next = sum[TD_W];
    end

    // q = a*a - a*b + b*b and nx, ny, numerators of the squared direction components
    always_comb
    begin
        qs = {{2{aa_reg[Q_W-1]}}, aa_reg} - {{2{ab_reg[Q_W-1]}}, ab_reg}
           + {{2{bb_reg[Q_W-1]}}, bb_reg};
        job_next.zero  = zero_reg;
        job_next.neg_x = negx_reg;
        job_next.neg_y = negy_reg;
        job_next.q     = qs[Q_W-1:0];
        job_next.nx    = ud2_reg + {ud2_reg[NX_W-2:0], 1'b0};
        job_next.ny    = us2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end
        else if (fe)
        begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            a_reg    <= in_data.time_diff_left;
            b_reg    <= in_data.time_diff_right;
            aa_reg   <= aa_next;
            ab_reg   <= ab_next;
            bb_reg   <= bb_next;
            ud2_reg  <= ud2_next;
            us2_reg  <= us2_next;
            zero_reg <= zero_next;
            negx_reg <= negx_next;
            negy_reg <= negy_next;
            job_reg  <= job_next;
        end
    end

endmodule

// ===== design/twd_queue.sv =====
`timescale 1ns / 1ps

module twd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  twd_pkg::twd_job_t push_job,
    output logic              full,
    input  logic              pop,
    output twd_pkg::twd_job_t pop_job,
    output logic              empty
);
    import twd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    twd_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/twd_back.sv =====
`timescale 1ns / 1ps

module twd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  twd_pkg::twd_cfg_t cfg,
    input  logic              q_empty,
    input  twd_pkg::twd_job_t job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output twd_pkg::twd_out_t out_data
);
    import twd_pkg::*;

    logic en;

    twd_div_lane_t  dvs_reg [DIV_STEPS+1], dvs_next [DIV_STEPS+1];
    twd_div_lane_t  dvx_reg [DIV_STEPS+1], dvx_next [DIV_STEPS+1];
    twd_div_lane_t  dvy_reg [DIV_STEPS+1], dvy_next [DIV_STEPS+1];
    twd_dmeta_t     dm_reg  [DIV_STEPS+1], dm_next  [DIV_STEPS+1];
    logic           dv_vld_reg [DIV_STEPS+1], dv_vld_next [DIV_STEPS+1];

    twd_sqrt_lane_t sqs_reg [SQRT_STEPS+1], sqs_next [SQRT_STEPS+1];
    twd_sqrt_lane_t sqx_reg [SQRT_STEPS+1], sqx_next [SQRT_STEPS+1];
    twd_sqrt_lane_t sqy_reg [SQRT_STEPS+1], sqy_next [SQRT_STEPS+1];
    twd_smeta_t     sm_reg  [SQRT_STEPS+1], sm_next  [SQRT_STEPS+1];
    logic           sq_vld_reg [SQRT_STEPS+1], sq_vld_next [SQRT_STEPS+1];

    twd_out_t       out_reg, out_next;
    logic           out_vld_reg;

    logic [SQ_W-1:0] spd_sq;
    logic [Q_W-1:0]  spd_rm;
    twd_dmeta_t      dl;
    twd_smeta_t      sl;

    assign en        = !out_vld_reg || !out_stall;
    assign pop       = en && !q_empty;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        // entry: load dividends, flag quotients of 2^32 and above
        dvs_next[0].r   = Q_W'(cfg.m2[M2_W-1:QUO_W]);
        dvs_next[0].low = cfg.m2[QUO_W-1:0];
        dvs_next[0].quo = '0;
        dvx_next[0].r   = Q_W'(job.nx[NX_W-1:3]);
        dvx_next[0].low = {job.nx[2:0], FRAC_BITS'(0)};
        dvx_next[0].quo = '0;
        dvy_next[0].r   = Q_W'(job.ny[NY_W-1:3]);
        dvy_next[0].low = {job.ny[2:0], FRAC_BITS'(0)};
        dvy_next[0].quo = '0;
        dm_next[0].zero  = job.zero;
        dm_next[0].big   = Q_W'(cfg.m2[M2_W-1:SQ_W]) >= job.q;
        dm_next[0].neg_x = job.neg_x;
        dm_next[0].neg_y = job.neg_y;
        dm_next[0].d     = job.zero ? Q_W'(1) : job.q;
        dv_vld_next[0]   = !q_empty;

        // one quotient bit per stage on all three dividers
        for (int s = 1; s <= DIV_STEPS; s++)
        begin
            dvs_next[s]    = div_step(dvs_reg[s-1], dm_reg[s-1].d);
            dvx_next[s]    = div_step(dvx_reg[s-1], dm_reg[s-1].d);
            dvy_next[s]    = div_step(dvy_reg[s-1], dm_reg[s-1].d);
            dm_next[s]     = dm_reg[s-1];
            dv_vld_next[s] = dv_vld_reg[s-1];
        end

        // speed limit test on the exact squared speed
        dl     = dm_reg[DIV_STEPS];
        spd_sq = dvs_reg[DIV_STEPS].quo[SQ_W-1:0];
        spd_rm = dvs_reg[DIV_STEPS].r;
        sm_next[0].zero  = dl.zero;
        sm_next[0].big   = dl.big;
        sm_next[0].ok    = !dl.zero && !dl.big && (spd_sq >= cfg.min_sq)
                         && ((spd_sq < cfg.max_sq)
                             || ((spd_sq == cfg.max_sq) && (spd_rm == '0)));
        sm_next[0].neg_x = dl.neg_x;
        sm_next[0].neg_y = dl.neg_y;
        sqs_next[0] = '{rad: {1'b0, dvs_reg[DIV_STEPS].quo}, rem: '0, root: '0};
        sqx_next[0] = '{rad: {1'b0, dvx_reg[DIV_STEPS].quo}, rem: '0, root: '0};
        sqy_next[0] = '{rad: {1'b0, dvy_reg[DIV_STEPS].quo}, rem: '0, root: '0};
        sq_vld_next[0] = dv_vld_reg[DIV_STEPS];

        // one root bit per stage
        for (int s = 1; s <= SQRT_STEPS; s++)
        begin
            sqs_next[s]    = sqrt_step(sqs_reg[s-1]);
            sqx_next[s]    = sqrt_step(sqx_reg[s-1]);
            sqy_next[s]    = sqrt_step(sqy_reg[s-1]);
            sm_next[s]     = sm_reg[s-1];
            sq_vld_next[s] = sq_vld_reg[s-1];
        end

        // rounding, saturation and sign of the directions; wind speed zero, saturated or root
        sl = sm_reg[SQRT_STEPS];
        out_next.estimate_valid = sl.ok;
        out_next.dir_x = sl.ok ? q15_signed(sqx_reg[SQRT_STEPS].root, sl.neg_x) : 16'sd0;
        out_next.dir_y = sl.ok ? q15_signed(sqy_reg[SQRT_STEPS].root, sl.neg_y) : 16'sd0;
        if (sl.zero)
        begin
            out_next.wind_speed = 16'd0;
        end
        else if (sl.big)
        begin
            out_next.wind_speed = 16'hFFFF;
        end
        else
        begin
            out_next.wind_speed = sqs_reg[SQRT_STEPS].root[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
            for (int s = 0; s <= SQRT_STEPS; s++)
            begin
                sq_vld_reg[s] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                dv_vld_reg[s] <= dv_vld_next[s];
            end
            for (int s = 0; s <= SQRT_STEPS; s++)
            begin
                sq_vld_reg[s] <= sq_vld_next[s];
            end
            out_vld_reg <= sq_vld_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                dvs_reg[s] <= dvs_next[s];
                dvx_reg[s] <= dvx_next[s];
                dvy_reg[s] <= dvy_next[s];
                dm_reg[s]  <= dm_next[s];
            end
            for (int s = 0; s <= SQRT_STEPS; s++)
            begin
                sqs_reg[s] <= sqs_next[s];
                sqx_reg[s] <= sqx_next[s];
                sqy_reg[s] <= sqy_next[s];
                sm_reg[s]  <= sm_next[s];
            end
            out_reg <= out_next;
        end
    end

endmodule

// ===== design/tdoa_wind_direction_estimator_top.sv =====
`timescale 1ns / 1ps

// wind direction and speed from the two arrival-time differences of a three-sensor
// triangle; takes one item per clock while in_stall is low and gives one result item per
// input item, in order; an item passes 57 register stages (3 front stages, the queue,
// the divider load stage, 33 restoring division stages with a 48-bit divisor, one
// limit-test stage, 17 square-root stages and the output register); the throughput is
// one item per cycle as long as out_stall stays low; in_stall rises only when the queue
// between front and back is full; configuration writes land in the configuration
// registers, m and the squared limits are registered from them and m2 from m, so
// write only while no item is in flight
module tdoa_wind_direction_estimator_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  twd_pkg::twd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output twd_pkg::twd_out_t out_data,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import twd_pkg::*;

    // configuration registers
    logic [9:0]      radius_reg;
    logic [15:0]     speed_max_reg;
    logic [15:0]     speed_min_reg;

    // derived: m = 1500000 * radius, its square, and the squared speed limits
    logic [M_W-1:0]  m_reg, m_next;
    logic [M2_W-1:0] m2_reg, m2_next;
    logic [SQ_W-1:0] min_sq_reg, min_sq_next;
    logic [SQ_W-1:0] max_sq_reg, max_sq_next;
    twd_cfg_t        cfg;

    // front to queue to back
    logic            push, q_full, pop, q_empty;
    twd_job_t        push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 10'd100;
            speed_max_reg <= 16'd5000;
            speed_min_reg <= 16'd10;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SENSOR_RADIUS: radius_reg    <= cfg_data[9:0];
                REG_SPEED_MAX:     speed_max_reg <= cfg_data;
                REG_SPEED_MIN:     speed_min_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        m_next      = SPEED_NUM * radius_reg;
        m2_next     = m_reg * m_reg;
        min_sq_next = speed_min_reg * speed_min_reg;
        max_sq_next = speed_max_reg * speed_max_reg;
    end

    // reset values match the reset configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg      <= 31'd150000000;
            m2_reg     <= 62'd22500000000000000;
            min_sq_reg <= 32'd100;
            max_sq_reg <= 32'd25000000;
        end
        else
        begin
            m_reg      <= m_next;
            m2_reg     <= m2_next;
            min_sq_reg <= min_sq_next;
            max_sq_reg <= max_sq_next;
        end
    end

    assign cfg.m2     = m2_reg;
    assign cfg.min_sq = min_sq_reg;
    assign cfg.max_sq = max_sq_reg;

    // front: squares and products of the differences, zero case flagged
    twd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    // short queue so the front keeps taking items while the back is held, until it is full
    twd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // back: pipelined divisions and square roots, limit test, output register
    twd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .job       (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
